[rtl/csb_pkg.sv]
`default_nettype none

package csb_pkg;

   localparam int unsigned CSB_BUCKETS   = 256;
   localparam int unsigned CSB_MAX_ITEMS = 4096;

   localparam int unsigned VALUE_W = 16;
   localparam int unsigned SPAN_W  = 9;
   localparam int unsigned COUNT_W = 13;
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_FULL  = 2'd2,
      STATUS_EMPTY = 2'd3
   } status_type;

   typedef enum logic {
      CMD_INSERT = 1'b0,
      CMD_POP    = 1'b1
   } command_type;

   typedef enum logic {
      CSR_WINDOW_BASE = 1'b0,
      CSR_BUCKET_SPAN = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_INS_RD,
      ST_POP_RD,
      ST_WAIT
   } state_type;

   typedef struct packed {
      status_type         status;
      logic [VALUE_W-1:0] value;
      logic               last;
   } result_type;

endpackage

`default_nettype wire

[rtl/csb_count_ram.sv]
`default_nettype none

module csb_count_ram
   import csb_pkg::*;
#(
   parameter int unsigned DEPTH = CSB_BUCKETS,
   localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
   input  wire logic               clock,
   input  wire logic               wr_en,
   input  wire logic [ADDR_W-1:0]  wr_addr,
   input  wire logic [COUNT_W-1:0] wr_data,
   input  wire logic [ADDR_W-1:0]  rd_addr,
   output logic      [COUNT_W-1:0] rd_data
);

   logic [COUNT_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

[rtl/counting_sort_buckets.sv]
// Counting sort over a programmable value window. An insert transaction
// (tuser 0) adds its value to the counter of bucket value - window_base; a
// pop transaction (tuser 1) returns the smallest stored value, tlast marking
// the last one held. Every transaction yields one response whose tuser
// carries the status. Bucket counters live in a single-port-read RAM, so an
// insert is accepted and then does one counter read-modify-write, also
// when it is refused because its counter is saturated; an insert refused as
// out of window or with MAX_ITEMS values held, and a pop on an empty store,
// are answered from the idle state; a pop reads one counter per cycle
// upward from its scan point past empty buckets. A response that finds
// the output slot full is held, and no transaction is accepted until it
// goes out. After reset a clearing pass zeroes the counters, during which
// no transaction is accepted; configuration writes are taken at any time.
`default_nettype none

module counting_sort_buckets
   import csb_pkg::*;
#(
   parameter int unsigned BUCKETS   = CSB_BUCKETS,
   parameter int unsigned MAX_ITEMS = CSB_MAX_ITEMS
) (
   input  wire logic                clock,
   input  wire logic                reset,

   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [VALUE_W-1:0]  req_tdata,   // [15:0] sample_value
   input  wire logic                req_tuser,   // [0] command

   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic      [VALUE_W-1:0]  rsp_tdata,   // [15:0] sorted_value
   output logic      [1:0]          rsp_tuser,   // [1:0] status
   output logic                     rsp_tlast,   // final_value

   input  wire logic                csr_we,
   input  wire logic                csr_index,
   input  wire logic [VALUE_W-1:0]  csr_wdata
);

   localparam int unsigned IDX_W  = $clog2(BUCKETS);
   localparam int unsigned ITEM_W = $clog2(MAX_ITEMS + 1);
   localparam int unsigned OFF_W  = VALUE_W + 1;
   localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(BUCKETS - 1);
   localparam logic [OFF_W-1:0]  LIM_MAX  = OFF_W'(BUCKETS);
   localparam logic [ITEM_W-1:0] ITEM_MAX = ITEM_W'(MAX_ITEMS);

   state_type           state_ff, state_in;
   logic [IDX_W-1:0]    cur_ff, cur_in;
   logic [IDX_W-1:0]    scan_ff, scan_in;
   logic [ITEM_W-1:0]   items_ff, items_in;
   logic [VALUE_W-1:0]  base_ff;
   logic [SPAN_W-1:0]   span_ff;
   result_type          hold_ff, hold_in;
   result_type          rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic                mem_we;
   logic [IDX_W-1:0]    mem_waddr;
   logic [COUNT_W-1:0]  mem_wdata;
   logic [IDX_W-1:0]    mem_raddr;
   logic [COUNT_W-1:0]  mem_rdata;

   logic [OFF_W-1:0]    offset;
   logic [OFF_W-1:0]    limit;
   logic                in_window;
   logic                accept;
   logic                slot_free;
   logic                fin_valid;
   result_type          fin;

   csb_count_ram #(
      .DEPTH (BUCKETS)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
         span_ff <= SPAN_W'(256);
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_WINDOW_BASE: base_ff <= csr_wdata;
            CSR_BUCKET_SPAN: span_ff <= csr_wdata[SPAN_W-1:0];
         endcase
      end
   end

   always_comb begin
      offset = OFF_W'($signed({req_tdata[VALUE_W-1], req_tdata})
                      - $signed({base_ff[VALUE_W-1], base_ff}));
      if (span_ff == '0) begin
         limit = OFF_W'(1);
      end else if (OFF_W'(span_ff) > LIM_MAX) begin
         limit = LIM_MAX;
      end else begin
         limit = OFF_W'(span_ff);
      end
      in_window = !offset[OFF_W-1] && (offset < limit);
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      scan_in      = scan_ff;
      items_in     = items_ff;
      hold_in      = hold_ff;
      mem_we       = 1'b0;
      mem_waddr    = cur_ff;
      mem_wdata    = '0;
      mem_raddr    = cur_ff;
      fin_valid    = 1'b0;
      fin          = '{status: STATUS_OK, value: '0, last: 1'b0};

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            cur_in = cur_ff + IDX_W'(1);
            if (cur_ff == LAST_IDX) begin
               cur_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (command_type'(req_tuser) == CMD_INSERT) begin
                  if (!in_window) begin
                     fin_valid  = 1'b1;
                     fin.status = STATUS_RANGE;
                  end else if (items_ff >= ITEM_MAX) begin
                     fin_valid  = 1'b1;
                     fin.status = STATUS_FULL;
                  end else begin
                     cur_in    = offset[IDX_W-1:0];
                     mem_raddr = offset[IDX_W-1:0];
                     state_in  = ST_INS_RD;
                  end
               end else begin
                  if (items_ff == '0) begin
                     fin_valid  = 1'b1;
                     fin.status = STATUS_EMPTY;
                  end else begin
                     cur_in    = scan_ff;
                     mem_raddr = scan_ff;
                     state_in  = ST_POP_RD;
                  end
               end
            end
         end
         ST_INS_RD: begin
            fin_valid = 1'b1;
            if (mem_rdata == COUNT_MAX) begin
               fin.status = STATUS_FULL;
            end else begin
               mem_we    = 1'b1;
               mem_wdata = mem_rdata + COUNT_W'(1);
               items_in  = items_ff + ITEM_W'(1);
               if (cur_ff < scan_ff) begin
                  scan_in = cur_ff;
               end
            end
         end
         ST_POP_RD: begin
            if (mem_rdata != '0) begin
               fin_valid = 1'b1;
               mem_we    = 1'b1;
               mem_wdata = mem_rdata - COUNT_W'(1);
               items_in  = items_ff - ITEM_W'(1);
               fin.value = base_ff + VALUE_W'(cur_ff);
               fin.last  = (items_ff == ITEM_W'(1));
               scan_in   = fin.last ? '0 : cur_ff;
            end else if (cur_ff == LAST_IDX) begin
               fin_valid  = 1'b1;
               fin.status = STATUS_EMPTY;
            end else begin
               cur_in    = cur_ff + IDX_W'(1);
               mem_raddr = cur_ff + IDX_W'(1);
            end
         end
         ST_WAIT: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (fin_valid) begin
         if (slot_free) begin
            state_in = ST_IDLE;
         end else begin
            hold_in  = fin;
            state_in = ST_WAIT;
         end
      end
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (fin_valid && slot_free) begin
         rsp_in       = fin;
         rsp_valid_in = 1'b1;
      end else if (state_ff == ST_WAIT && slot_free) begin
         rsp_in       = hold_ff;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cur_ff       <= '0;
         scan_ff      <= '0;
         items_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         scan_ff      <= scan_in;
         items_ff     <= items_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff.value;
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tlast  = rsp_ff.last;

   a_clear_blocks_input: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !req_tready)
      else $error("transaction accepted during counter clear");

   a_last_is_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser == STATUS_OK && rsp_ff.status == STATUS_OK)
      else $error("last flag on a response that delivered nothing");

   a_empty_scan_home: assert property (@(posedge clock) disable iff (reset)
      items_ff == '0 |-> scan_ff == '0)
      else $error("scan point not at bucket zero with empty store");

   a_pop_has_items: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_POP_RD |-> items_ff != '0)
      else $error("pop scan running with empty store");

   a_wait_holds_slot: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WAIT |-> rsp_tvalid)
      else $error("pending response held while output slot is free");

endmodule

`default_nettype wire
